FILE: rtl/core/drx_pkg.sv
package drx_pkg;

  // Default width of the saturating message byte counter
  localparam int DRX_OFFSET_BITS = 16;

  // DNS field constants
  localparam logic [7:0]  PTR_MARK       = 8'hC0;
  localparam logic [7:0]  RCODE_MASK     = 8'h0F;
  localparam logic [15:0] QTAIL_LEN      = 16'd5;
  localparam logic [15:0] RECORD_HDR_LEN = 16'd10;
  localparam logic [15:0] TYPE_A         = 16'd1;
  localparam logic [15:0] CLASS_IN       = 16'd1;
  localparam logic [15:0] IPV4_LEN       = 16'd4;

  // Result cause codes
  localparam logic [2:0] CAUSE_FOUND      = 3'd0;
  localparam logic [2:0] CAUSE_RCODE      = 3'd1;
  localparam logic [2:0] CAUSE_SHORT      = 3'd2;
  localparam logic [2:0] CAUSE_QCOUNT     = 3'd3;
  localparam logic [2:0] CAUSE_Q_OVERRUN  = 3'd4;
  localparam logic [2:0] CAUSE_A_OVERRUN  = 3'd5;
  localparam logic [2:0] CAUSE_RR_BEYOND  = 3'd6;
  localparam logic [2:0] CAUSE_NONE       = 3'd7;

  // Parse phase
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QPTR   = 4'd3,
    PH_QTAIL  = 4'd4,
    PH_ANAME  = 4'd5,
    PH_ALABEL = 4'd6,
    PH_APTR   = 4'd7,
    PH_RECORD = 4'd8,
    PH_RDATA  = 4'd9
  } drx_phase_t;

  // One result per message
  typedef struct packed {
    logic [31:0] ipv4_address;
    logic [15:0] message_id;
    logic [3:0]  reply_code;
    logic [2:0]  cause;
    logic        failed;
  } drx_result_t;

endpackage

FILE: rtl/core/dns_reply_ipv4_extractor.sv
// DNS reply IPv4 extractor.
// Input stream: one DNS message byte per request on in_tdata, in_tlast on the
// final byte. Output stream: one request per message, issued for its final
// byte, carrying the header ID, reply code, first A/IN address and a cause.
// Bytes pass through an input register into a per-byte parse state machine
// and the result lands in an output register; no stage iterates.
// Throughput: one byte per cycle, messages back to back, except while a final
// byte is held; out_tvalid is registered when that final byte advances.
// The output register stalls on out_tready low; while it is full only a
// final byte waits in the input register, other bytes keep flowing, so
// in_tready drops only when a second result would collide with the first.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// at the start of a message; every final byte does the same for the parser.
// The byte counter saturates at its maximum, only the header uses it.
module dns_reply_ipv4_extractor #(
  parameter int OFFSET_BITS = drx_pkg::DRX_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [0] failed, [3:1] cause, [7:4] reply_code,
                                  // [23:8] message_id, [55:24] ipv4_address
);
  import drx_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        advance;
  logic        out_valid_r;
  drx_result_t out_data_r;
  drx_result_t result;

  // A final byte may only advance when the output register can take it
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  drx_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .result    (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.ipv4_address, out_data_r.message_id,
                       out_data_r.reply_code, out_data_r.cause, out_data_r.failed};

  // failed follows the cause code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.failed == (out_data_r.cause >= CAUSE_SHORT)))
    else $error("failed flag disagrees with cause");

  // an address is only reported when one was found
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.cause != CAUSE_FOUND) |-> (out_data_r.ipv4_address == 32'd0))
    else $error("address reported without a match");

  // a short header reports no header fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.cause == CAUSE_SHORT) |->
      (out_data_r.message_id == 16'd0) && (out_data_r.reply_code == 4'd0))
    else $error("short header reports header fields");

  // a held final byte stays in the input register until it advances
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && in_last_r && $stable(in_byte_r))
    else $error("stalled byte lost from input register");

  // an unread result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

FILE: rtl/core/drx_parser.sv
module drx_parser #(
  parameter int OFFSET_BITS = drx_pkg::DRX_OFFSET_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output drx_pkg::drx_result_t result
);
  import drx_pkg::*;

  drx_phase_t             phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [15:0]            skip_r, skip_nxt;
  logic [15:0]            ans_r, ans_nxt;
  logic [15:0]            ans_dec;
  logic [15:0]            id_r, id_nxt;
  logic [3:0]             rcode_r, rcode_nxt;
  logic [15:0]            qd_r, qd_nxt;
  logic [47:0]            rec_r, rec_nxt;
  logic [31:0]            addr_r, addr_nxt;
  logic                   decided_r, decided_nxt;
  logic [2:0]             cause_r, cause_nxt;
  logic [15:0]            skip_dec;
  logic                   rec_match;
  logic                   rec_shift;
  logic [2:0]             end_cause;

  assign skip_dec  = skip_r - 16'd1;
  assign ans_dec   = ans_r - 16'd1;
  assign rec_match = (rec_r[47:32] == TYPE_A) && (rec_r[31:16] == CLASS_IN) &&
                     (rec_r[15:0] == IPV4_LEN);
  // Type and class are the first four record header bytes, length the last two
  assign rec_shift = (skip_r > (RECORD_HDR_LEN - 16'd4)) || (skip_r <= 16'd2);

  // Per-byte state update
  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    ans_nxt     = ans_r;
    id_nxt      = id_r;
    rcode_nxt   = rcode_r;
    qd_nxt      = qd_r;
    rec_nxt     = rec_r;
    addr_nxt    = addr_r;
    decided_nxt = decided_r;
    cause_nxt   = cause_r;
    off_nxt     = (off_r == '1) ? off_r : off_r + 1'b1;

    if (!decided_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (off_r < OFFSET_BITS'(8)) begin
            case (off_r[2:0])
              3'd0: id_nxt[15:8] = data_byte;
              3'd1: id_nxt[7:0]  = data_byte;
              3'd3: rcode_nxt    = data_byte[3:0] & RCODE_MASK[3:0];
              3'd4: qd_nxt[15:8] = data_byte;
              3'd5: qd_nxt[7:0]  = data_byte;
              3'd6: ans_nxt[15:8] = data_byte;
              3'd7: ans_nxt[7:0]  = data_byte;
              default: ;
            endcase
          end
          if (off_r == OFFSET_BITS'(11)) begin
            if (rcode_r != 4'd0) begin
              decided_nxt = 1'b1;
              cause_nxt   = CAUSE_RCODE;
            end else if (qd_r != 16'd1) begin
              decided_nxt = 1'b1;
              cause_nxt   = CAUSE_QCOUNT;
            end else begin
              phase_nxt = PH_QNAME;
            end
          end
        end
        PH_QNAME: begin
          if (data_byte == 8'd0) begin
            skip_nxt  = QTAIL_LEN - 16'd1;
            phase_nxt = PH_QTAIL;
          end else if ((data_byte & PTR_MARK) == PTR_MARK) begin
            phase_nxt = PH_QPTR;
          end else begin
            skip_nxt  = {8'd0, data_byte};
            phase_nxt = PH_QLABEL;
          end
        end
        PH_QLABEL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) phase_nxt = PH_QNAME;
        end
        PH_QPTR: begin
          skip_nxt  = QTAIL_LEN - 16'd1;
          phase_nxt = PH_QTAIL;
        end
        PH_QTAIL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            if (ans_r == 16'd0) begin
              decided_nxt = 1'b1;
              cause_nxt   = CAUSE_NONE;
            end else begin
              phase_nxt = PH_ANAME;
            end
          end
        end
        PH_ANAME: begin
          if (data_byte == 8'd0) begin
            skip_nxt  = RECORD_HDR_LEN;
            rec_nxt   = '0;
            phase_nxt = PH_RECORD;
          end else if ((data_byte & PTR_MARK) == PTR_MARK) begin
            phase_nxt = PH_APTR;
          end else begin
            skip_nxt  = {8'd0, data_byte};
            phase_nxt = PH_ALABEL;
          end
        end
        PH_ALABEL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) phase_nxt = PH_ANAME;
        end
        PH_APTR: begin
          skip_nxt  = RECORD_HDR_LEN;
          rec_nxt   = '0;
          phase_nxt = PH_RECORD;
        end
        PH_RECORD: begin
          if (rec_shift) rec_nxt = {rec_r[39:0], data_byte};
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            // Record header complete: rec_nxt holds the data length
            if (rec_nxt[15:0] == 16'd0) begin
              ans_nxt = ans_dec;
              if (ans_dec == 16'd0) begin
                decided_nxt = 1'b1;
                cause_nxt   = CAUSE_NONE;
              end else begin
                phase_nxt = PH_ANAME;
              end
            end else begin
              skip_nxt  = rec_nxt[15:0];
              phase_nxt = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          if (rec_match) addr_nxt = {addr_r[23:0], data_byte};
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            if (rec_match) begin
              decided_nxt = 1'b1;
              cause_nxt   = CAUSE_FOUND;
            end else begin
              ans_nxt = ans_dec;
              if (ans_dec == 16'd0) begin
                decided_nxt = 1'b1;
                cause_nxt   = CAUSE_NONE;
              end else begin
                phase_nxt = PH_ANAME;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Cause when the message ends after this byte
  always_comb begin
    if (decided_nxt) begin
      end_cause = cause_nxt;
    end else begin
      case (phase_nxt)
        PH_HEADER: end_cause = CAUSE_SHORT;
        PH_QNAME, PH_QLABEL, PH_QPTR: end_cause = CAUSE_Q_OVERRUN;
        PH_QTAIL: end_cause = (ans_nxt != 16'd0) ? CAUSE_A_OVERRUN : CAUSE_NONE;
        PH_ANAME, PH_ALABEL: end_cause = CAUSE_A_OVERRUN;
        PH_APTR, PH_RECORD, PH_RDATA: end_cause = CAUSE_RR_BEYOND;
        default: end_cause = CAUSE_NONE;
      endcase
    end
  end

  // Result fields, valid when the final byte is stepped
  always_comb begin
    result.failed       = (end_cause >= CAUSE_SHORT);
    result.cause        = end_cause;
    result.reply_code   = (end_cause == CAUSE_SHORT) ? 4'd0 : rcode_nxt;
    result.message_id   = (end_cause == CAUSE_SHORT) ? 16'd0 : id_nxt;
    result.ipv4_address = (end_cause == CAUSE_FOUND) ? addr_nxt : 32'd0;
  end

  // Control state; the final byte returns the parser to its start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      off_r     <= '0;
      decided_r <= 1'b0;
      cause_r   <= CAUSE_FOUND;
      skip_r    <= '0;
    end else if (step) begin
      if (last_byte) begin
        phase_r   <= PH_HEADER;
        off_r     <= '0;
        decided_r <= 1'b0;
        cause_r   <= CAUSE_FOUND;
        skip_r    <= '0;
      end else begin
        phase_r   <= phase_nxt;
        off_r     <= off_nxt;
        decided_r <= decided_nxt;
        cause_r   <= cause_nxt;
        skip_r    <= skip_nxt;
      end
    end
  end

  // Captured header and record fields, each rewritten before it is used
  always_ff @(posedge clk) begin
    if (step) begin
      ans_r   <= ans_nxt;
      id_r    <= id_nxt;
      rcode_r <= rcode_nxt;
      qd_r    <= qd_nxt;
      rec_r   <= rec_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule
